[rtl/indexed_list_insert_remove_core_macros.svh]
// Assertion macros shared by the indexed list core modules.
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ilir_pkg.sv]
// Package: word types, operation and status codes, controller/datapath link types.
package ilir_pkg;

    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_APPEND = 2'd0;
    localparam t_func FUNC_GET    = 2'd1;
    localparam t_func FUNC_REMOVE = 2'd2;
    localparam t_func FUNC_INSERT = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_INDEX = 2'd1;
    localparam t_status ST_NULL      = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef struct packed {
        t_func             func;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  entry_value;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  read_value;
        logic [CNT_W-1:0]  item_count;
    } t_out_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic set_status;
        logic wr_append;
        logic rd_get;
        logic init_idx;
        logic move_rd;
        logic move_wr;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic  ok;
        t_func func;
        logic  more;
    } t_dp_stat;

endpackage

[rtl/ilir_dp.sv]
// Datapath: request registers, slot memory, fill count, walk index and result register.
`include "indexed_list_insert_remove_core_macros.svh"

module ilir_dp #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ilir_pkg::t_in_word  i_req,
    input  ilir_pkg::t_dp_cmd   i_cmd,
    output ilir_pkg::t_dp_stat  o_stat,
    output ilir_pkg::t_out_word o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;

    ilir_pkg::t_func           r_func;
    logic [ilir_pkg::POS_W-1:0] r_pos;
    logic [ENTRY_WIDTH-1:0]    r_word;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CW-1:0]             r_idx;
    ilir_pkg::t_status         r_status;
    logic [ENTRY_WIDTH-1:0]    r_mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0]    r_rdata;
    ilir_pkg::t_out_word       r_res;

    logic [63:0]               in_ext;
    logic [63:0]               rd_ext;
    logic [XW-1:0]             pos_x;
    logic [XW-1:0]             cnt_x;
    logic [XW-1:0]             idx_x;
    logic [CW-1:0]             idx_inc;
    logic [CW-1:0]             idx_dec;
    logic                      full;
    logic                      null_w;
    ilir_pkg::t_status         status;
    logic                      more;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [ENTRY_WIDTH-1:0]    wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;

    assign in_ext  = 64'(i_req.entry_value);
    assign rd_ext  = 64'(r_rdata);
    assign pos_x   = XW'(r_pos);
    assign cnt_x   = XW'(r_count);
    assign idx_x   = XW'(r_idx);
    assign idx_inc = r_idx + CW'(1);
    assign idx_dec = r_idx - CW'(1);
    assign full    = (r_count == CW'(CAPACITY));
    assign null_w  = (r_word == '0);

    always_comb begin
        case (r_func)
            ilir_pkg::FUNC_APPEND: begin
                if (null_w)    status = ilir_pkg::ST_NULL;
                else if (full) status = ilir_pkg::ST_FULL;
                else           status = ilir_pkg::ST_OK;
            end
            ilir_pkg::FUNC_GET, ilir_pkg::FUNC_REMOVE: begin
                status = (pos_x >= cnt_x) ? ilir_pkg::ST_BAD_INDEX : ilir_pkg::ST_OK;
            end
            ilir_pkg::FUNC_INSERT: begin
                if (null_w)             status = ilir_pkg::ST_NULL;
                else if (pos_x > cnt_x) status = ilir_pkg::ST_BAD_INDEX;
                else if (full)          status = ilir_pkg::ST_FULL;
                else                    status = ilir_pkg::ST_OK;
            end
            default: status = ilir_pkg::ST_OK;
        endcase
    end

    // Remove walks up from the hole, insert walks down from the tail
    assign more = (r_func == ilir_pkg::FUNC_REMOVE) ? (idx_inc < r_count) : (idx_x > pos_x);

    assign o_stat.ok   = (status == ilir_pkg::ST_OK);
    assign o_stat.func = r_func;
    assign o_stat.more = more;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = r_word;
        if (i_cmd.wr_append) begin
            wr_en = 1'b1;
        end else if (i_cmd.move_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[AW-1:0];
            wr_data = r_rdata;
        end else if (i_cmd.commit && r_func == ilir_pkg::FUNC_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = pos_x[AW-1:0];
        end
    end

    always_comb begin
        rd_en   = i_cmd.rd_get | i_cmd.move_rd;
        rd_addr = pos_x[AW-1:0];
        if (i_cmd.move_rd) begin
            rd_addr = (r_func == ilir_pkg::FUNC_REMOVE) ? idx_inc[AW-1:0] : idx_dec[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.wr_append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.commit) begin
            n_count = (r_func == ilir_pkg::FUNC_INSERT) ? r_count + CW'(1) : r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_pos  <= i_req.position;
            r_word <= in_ext[ENTRY_WIDTH-1:0];
        end
        if (i_cmd.set_status) begin
            r_status <= status;
        end
        if (i_cmd.init_idx) begin
            r_idx <= (r_func == ilir_pkg::FUNC_REMOVE) ? pos_x[CW-1:0] : r_count;
        end else if (i_cmd.move_wr) begin
            r_idx <= (r_func == ilir_pkg::FUNC_REMOVE) ? idx_inc : idx_dec;
        end
        if (i_cmd.load_out) begin
            r_res.status     <= r_status;
            r_res.read_value <= (r_func == ilir_pkg::FUNC_GET && r_status == ilir_pkg::ST_OK)
                                ? rd_ext[ilir_pkg::VAL_W-1:0] : '0;
            r_res.item_count <= cnt_x[ilir_pkg::CNT_W-1:0];
        end
    end

    assign o_res = r_res;

    `ILIR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "fill count above capacity")
    `ILIR_ASSERT_NEXT(a_append_count, i_cmd.wr_append, r_count == $past(r_count) + CW'(1), "append did not bump count")
    `ILIR_ASSERT_NEXT(a_read_zero, i_cmd.load_out, r_res.status == ilir_pkg::ST_OK || r_res.read_value == '0, "failed word carries data")

endmodule

[rtl/ilir_ctrl.sv]
// Controller: request sequencing state machine and result valid flag.
`include "indexed_list_insert_remove_core_macros.svh"

module ilir_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ilir_pkg::t_dp_stat i_stat,
    output ilir_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECIDE    = 8'b0000_0010,
        S_GET_WAIT  = 8'b0000_0100,
        S_SHIFT_CHK = 8'b0000_1000,
        S_MOVE_RD   = 8'b0001_0000,
        S_MOVE_WR   = 8'b0010_0000,
        S_COMMIT    = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_status = 1'b1;
                if (!i_stat.ok) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_stat.func)
                        ilir_pkg::FUNC_APPEND: begin
                            o_cmd.wr_append = 1'b1;
                            n_state         = S_FINISH;
                        end
                        ilir_pkg::FUNC_GET: begin
                            o_cmd.rd_get = 1'b1;
                            n_state      = S_GET_WAIT;
                        end
                        default: begin
                            o_cmd.init_idx = 1'b1;
                            n_state        = S_SHIFT_CHK;
                        end
                    endcase
                end
            end
            S_GET_WAIT: begin
                n_state = S_FINISH;
            end
            S_SHIFT_CHK: begin
                n_state = i_stat.more ? S_MOVE_RD : S_COMMIT;
            end
            S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = S_SHIFT_CHK;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ILIR_ASSERT_NOW(a_out_free, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten before taken")
    `ILIR_ASSERT_NEXT(a_accept_decide, i_in_valid && o_in_ready, r_state == S_DECIDE, "accepted word not decoded")

endmodule

[rtl/indexed_list_insert_remove_core.sv]
// Top level of the indexed list core: controller plus datapath.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+---------------------------------
//   request | in        | i_in_valid / o_in_ready   | i_in_word  (func, position, entry)
//   result  | out       | o_out_valid / i_out_ready | o_out_word (status, read, count)
//
// One request at a time. After decode, the result register loads from S_FINISH, reached
// straight away for append and every failed request, via S_GET_WAIT for get, and via
// S_SHIFT_CHK and S_COMMIT for remove and insert, which move at most CAPACITY-1 slots:
// each move is a check, a read and a write on the slot memory. The next request is taken
// in the cycle after the result loads.
// Reset clears the fill count and control state only; slot contents are left as is.
// A result waiting on i_out_ready stalls the next request only at its final step.
module indexed_list_insert_remove_core #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ilir_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ilir_pkg::t_out_word o_out_word
);

    ilir_pkg::t_dp_cmd  dp_cmd;
    ilir_pkg::t_dp_stat dp_stat;

    ilir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ilir_dp #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_word),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_res   (o_out_word)
    );

endmodule
